[sv/mlpf_pkg.sv]
// Shared constants, codes and types of the multilevel priority FIFO.
package mlpf_pkg;

    localparam int LEVELS      = 8;
    localparam int LEVEL_DEPTH = 16;
    localparam int ITEM_BITS   = 32;

    localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PTR_W     = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CNT_W     = $clog2(LEVEL_DEPTH + 1);
    localparam int TOT_W     = $clog2(LEVELS * LEVEL_DEPTH + 1);
    localparam int ADDR_W    = LVL_W + PTR_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;

    // Stream payload layout.
    localparam int S_DATA_W = 40;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 88;

    localparam int O_REMOVED_ITEM  = 0;
    localparam int O_REMOVED_VALID = 32;
    localparam int O_HEAD_ITEM     = 33;
    localparam int O_HEAD_VALID    = 65;
    localparam int O_ALL_EMPTY     = 66;
    localparam int O_TOTAL_COUNT   = 67;
    localparam int O_LEVEL_COUNT   = 75;
    localparam int O_DROPPED       = 80;
    localparam int O_USED_W        = 81;

    typedef enum logic [1:0] {
        ACT_INSERT    = 2'd0,
        ACT_POP       = 2'd1,
        ACT_POP_LEVEL = 2'd2,
        ACT_QUERY     = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_HEAD,
        ST_RESP
    } state_t;

endpackage

[sv/mlpf_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module mlpf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/multilevel_priority_fifo.sv]
// Top level of the multilevel priority FIFO: sequencer, level pointers and status.
//
// The block keeps eight FIFO queues of 32-bit items in one shared slot RAM;
// the highest level is the most urgent. Each input word on the s_ channel
// carries an action in s_tuser (insert, pop highest, pop named level, query)
// and a level number and an item in s_tdata. For every accepted word exactly
// one status word leaves on the m_ channel: the removed item, the head of the
// highest non-empty level, the empty flag, the total and per-level counts,
// and a drop flag for an insert into a full level.
// An input word is accepted when s_tvalid and s_tready are both high. The
// result register is loaded after the execute and head states: the idle state
// accepts, the execute state updates pointers and issues the pop read, the
// head state reads the new head, the response state loads the result. The
// head read needs the pointers that the pop has moved, and the sequencer
// takes no new word before the result is loaded.
// A waiting result does not block acceptance of the next word; only the
// final load waits while m_tvalid is high and m_tready is low.
// Synchronous reset (aresetn low) empties every level and drops any result
// in flight. The slot RAM is not cleared; reads of unwritten slots are masked.
module multilevel_priority_fifo (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0 up: level (3), item (32), zero fill.
    input  logic [mlpf_pkg::S_DATA_W-1:0]   s_tdata,
    // Fields from bit 0 up: action (2).
    input  logic [mlpf_pkg::S_USER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0 up: removed_item (32), removed_valid (1), head_item (32),
    // head_valid (1), all_empty (1), total_count (8), level_count (5),
    // dropped (1), zero fill.
    output logic [mlpf_pkg::M_DATA_W-1:0]   m_tdata
);

    import mlpf_pkg::*;

    state_t state_reg, state_next;

    // Word latched at acceptance.
    action_t            act_reg;
    logic [2:0]         lv_reg;
    logic [ITEM_BITS-1:0] item_reg;

    // Per-level queue state.
    logic [PTR_W-1:0] head_ptr_reg [LEVELS];
    logic [PTR_W-1:0] tail_ptr_reg [LEVELS];
    logic [CNT_W-1:0] cnt_reg      [LEVELS];
    logic [TOT_W-1:0] total_reg;

    // Per-word results collected along the way.
    logic                 rvalid_reg;
    logic                 drop_reg;
    logic [ITEM_BITS-1:0] removed_reg;

    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    // RAM connections.
    logic                 ram_wr_en;
    logic [ADDR_W-1:0]    ram_wr_addr;
    logic                 ram_rd_en;
    logic [ADDR_W-1:0]    ram_rd_addr;
    logic [ITEM_BITS-1:0] ram_rd_data;

    logic             top_valid;
    logic [LVL_W-1:0] top_idx;
    logic             lv_ok;
    logic [LVL_W-1:0] lv_idx;
    logic [LVL_W-1:0] tgt_idx;
    logic             tgt_ok;
    logic [LVL_W-1:0] cnt_sel;
    logic [LVL_W-1:0] ptr_sel;
    logic [CNT_W-1:0] sel_cnt;
    logic [PTR_W-1:0] sel_head;
    logic [PTR_W-1:0] sel_tail;
    logic             level_full;
    logic             do_ins;
    logic             do_pop;
    logic             load_out;
    logic [M_DATA_W-1:0] result_word;

    // Highest non-empty level, from the counts held in flip-flops.
    always_comb begin
        top_valid = 1'b0;
        top_idx   = '0;
        for (int l = 0; l < LEVELS; l++) begin
            if (cnt_reg[l] != '0) begin
                top_valid = 1'b1;
                top_idx   = LVL_W'(l);
            end
        end
    end

    assign lv_ok  = (32'(lv_reg) < LEVELS);
    assign lv_idx = LVL_W'(lv_reg);

    // The level that the action works on: the top level for a plain pop.
    assign tgt_idx = (act_reg == ACT_POP) ? top_idx : lv_idx;
    assign tgt_ok  = (act_reg == ACT_POP) ? top_valid : lv_ok;

    // One count selector and one head-pointer selector, shared over the states.
    assign cnt_sel  = (state_reg == ST_EXEC) ? tgt_idx : lv_idx;
    assign ptr_sel  = (state_reg == ST_EXEC) ? tgt_idx : top_idx;
    assign sel_cnt  = cnt_reg[cnt_sel];
    assign sel_head = head_ptr_reg[ptr_sel];
    assign sel_tail = tail_ptr_reg[tgt_idx];

    assign level_full = (sel_cnt >= CNT_W'(LEVEL_DEPTH));

    assign do_ins = (state_reg == ST_EXEC) && (act_reg == ACT_INSERT) && lv_ok && !level_full;
    assign do_pop = (state_reg == ST_EXEC) &&
                    ((act_reg == ACT_POP) || (act_reg == ACT_POP_LEVEL)) &&
                    tgt_ok && (sel_cnt != '0);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_HEAD;
            end
            ST_HEAD: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        s_tready    = 1'b0;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        load_out    = 1'b0;
        ram_wr_addr = {tgt_idx, sel_tail};
        ram_rd_addr = {ptr_sel, sel_head};
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_EXEC: begin
                ram_wr_en = do_ins;
                ram_rd_en = do_pop;
            end
            ST_HEAD: begin
                ram_rd_en = 1'b1;
            end
            ST_RESP: begin
                load_out = !out_valid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // The head read returns in the response state.
    always_comb begin
        result_word = '0;
        result_word[O_REMOVED_ITEM +: 32] = rvalid_reg ? 32'(removed_reg) : 32'd0;
        result_word[O_REMOVED_VALID]      = rvalid_reg;
        result_word[O_HEAD_ITEM +: 32]    = top_valid ? 32'(ram_rd_data) : 32'd0;
        result_word[O_HEAD_VALID]         = top_valid;
        result_word[O_ALL_EMPTY]          = !top_valid;
        result_word[O_TOTAL_COUNT +: 8]   = 8'(total_reg);
        result_word[O_LEVEL_COUNT +: 5]   = lv_ok ? 5'(sel_cnt) : 5'd0;
        result_word[O_DROPPED]            = drop_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            for (int l = 0; l < LEVELS; l++) begin
                head_ptr_reg[l] <= '0;
                tail_ptr_reg[l] <= '0;
                cnt_reg[l]      <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (do_ins) begin
                tail_ptr_reg[tgt_idx] <= (sel_tail == PTR_W'(LEVEL_DEPTH - 1)) ?
                                         '0 : sel_tail + 1'b1;
                cnt_reg[tgt_idx]      <= sel_cnt + 1'b1;
                total_reg             <= total_reg + 1'b1;
            end else if (do_pop) begin
                head_ptr_reg[tgt_idx] <= (sel_head == PTR_W'(LEVEL_DEPTH - 1)) ?
                                         '0 : sel_head + 1'b1;
                cnt_reg[tgt_idx]      <= sel_cnt - 1'b1;
                total_reg             <= total_reg - 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            act_reg  <= action_t'(s_tuser[1:0]);
            lv_reg   <= s_tdata[2:0];
            item_reg <= ITEM_BITS'(s_tdata[34:3]);
        end
        if (state_reg == ST_EXEC) begin
            rvalid_reg <= do_pop;
            drop_reg   <= (act_reg == ACT_INSERT) && lv_ok && level_full;
        end
        if (state_reg == ST_HEAD) begin
            removed_reg <= ram_rd_data;
        end
        if (load_out) begin
            out_data_reg <= result_word;
        end
    end

    mlpf_ram #(
        .WIDTH (ITEM_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (item_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[sv/mlpf_checker.sv]
// Port-level assertions for the multilevel priority FIFO and their bind.
module mlpf_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [mlpf_pkg::S_DATA_W-1:0] s_tdata,
    input logic [mlpf_pkg::S_USER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mlpf_pkg::M_DATA_W-1:0] m_tdata
);

    import mlpf_pkg::*;

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // The sequencer takes one word at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // The head valid flag and the empty flag are always opposite.
    a_head_vs_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[O_HEAD_VALID] != m_tdata[O_ALL_EMPTY])
        else $error("head valid and empty flags agree");

    // An empty queue reports a total count of zero.
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[O_ALL_EMPTY] |->
            m_tdata[O_TOTAL_COUNT +: 8] == 8'd0 && !m_tdata[O_REMOVED_VALID] ||
            m_tvalid && m_tdata[O_ALL_EMPTY] && m_tdata[O_TOTAL_COUNT +: 8] == 8'd0)
        else $error("empty flag with a nonzero total count");

    // A word cannot both remove and drop an item.
    a_remove_or_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[O_REMOVED_VALID] && m_tdata[O_DROPPED]))
        else $error("removed and dropped flags both set");

endmodule

bind multilevel_priority_fifo mlpf_checker u_mlpf_checker (.*);
